FILE: rtl/sactag_pkg.sv
// Package for the set-associative cache tag store.
// Holds sizes, configuration register codes, item types and the set row layout.
// No dependencies; every other file but sactag_ram uses it.
package sactag_pkg;

    localparam int ADDR_W       = 32;
    localparam int TAG_W        = 32;
    localparam int STAMP_W      = 32;
    // Number of sets; a power of two
    localparam int MAX_SETS     = 64;
    localparam int NUM_WAYS     = 8;
    localparam int SET_W        = $clog2(MAX_SETS);
    localparam int MAX_SET_BITS = $clog2(MAX_SETS);
    localparam int WAY_W        = 3;
    localparam int LRU_LVLS     = $clog2(NUM_WAYS);

    // Configuration register widths and codes
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 4;
    localparam int SBITS_W      = 3;
    localparam int OBITS_W      = 4;
    localparam int WAYS_CFG_W   = 4;
    localparam int SHAMT_W      = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS        = 2'd2;

    localparam logic [SBITS_W-1:0]    SBITS_RST = 3'd4;
    localparam logic [OBITS_W-1:0]    OBITS_RST = 4'd3;
    localparam logic [WAYS_CFG_W-1:0] WAYS_RST  = 4'd8;

    // Depth of the queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Classified item handed from front to back
    typedef struct packed {
        logic                  func;
        logic [SET_W-1:0]      set;
        logic [TAG_W-1:0]      tag;
        logic [WAYS_CFG_W-1:0] ways;
    } t_work;

    // Result item
    typedef struct packed {
        logic             hit;
        logic             writeback;
        logic [WAY_W-1:0] way_used;
        logic             was_write;
    } t_rsp;

    // One set as stored in the tag memory
    typedef struct packed {
        logic [NUM_WAYS-1:0]              valid;
        logic [NUM_WAYS-1:0]              dirty;
        logic [NUM_WAYS-1:0][TAG_W-1:0]   tag;
        logic [NUM_WAYS-1:0][STAMP_W-1:0] stamp;
    } t_row;

    localparam int ROW_W = $bits(t_row);

    typedef enum logic [1:0] {
        BS_IDLE,
        BS_LOOK,
        BS_UPDATE
    } t_bstate;

endpackage

FILE: rtl/sactag_intf.sv
// Channel interfaces: access requests, results and configuration writes.
// Depends on sactag_pkg for field widths.
interface sactag_req_if;
    logic                          valid;
    logic                          ready;
    logic                          func;
    logic [sactag_pkg::ADDR_W-1:0] address;
    modport source (output valid, func, address, input ready);
    modport sink   (input valid, func, address, output ready);
endinterface

interface sactag_rsp_if;
    logic                         valid;
    logic                         ready;
    logic                         hit;
    logic                         writeback;
    logic [sactag_pkg::WAY_W-1:0] way_used;
    logic                         was_write;
    modport source (output valid, hit, writeback, way_used, was_write, input ready);
    modport sink   (input valid, hit, writeback, way_used, was_write, output ready);
endinterface

interface sactag_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [sactag_pkg::CFG_IDX_W-1:0]  index;
    logic [sactag_pkg::CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/set_assoc_lru_writeback_cache_tags_top.sv
// Top level of the set-associative LRU write-back cache tag store.
// Depends on sactag_pkg, the channel interfaces, sactag_front, sactag_fifo, sactag_back.
//
//  Port      Dir  Handshake    Carries
//  i_req     in   valid/ready  func, address
//  o_rsp     out  valid/ready  hit, writeback, way_used, was_write
//  i_cfg     in   valid/ready  index, data (ready always high)
//
// Each access passes through the back end in order: set row read, tag search and
// LRU choice, row write with result load. The single port pair of the tag memory
// and its read-modify-write of one row keep the back end to one access at a time.
// Reset is synchronous; no clearing pass, rows carry valid flags instead.
// A two-entry queue lets requests be taken while a result waits on o_rsp.
module set_assoc_lru_writeback_cache_tags_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sactag_req_if.sink  i_req,
    sactag_rsp_if.source o_rsp,
    sactag_cfg_if.sink  i_cfg
);
    import sactag_pkg::*;

    logic  push;
    logic  full;
    logic  pop;
    logic  q_valid;
    t_work front_work;
    t_work q_work;

    sactag_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_cfg   (i_cfg),
        .i_full  (full),
        .o_push  (push),
        .o_work  (front_work)
    );

    sactag_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_work  (front_work),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_work  (q_work)
    );

    sactag_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_work_valid (q_valid),
        .i_work       (q_work),
        .o_pop        (pop),
        .o_rsp        (o_rsp)
    );

endmodule

FILE: rtl/sactag_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sactag_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/sactag_front.sv
// Front end: configuration registers, request acceptance and address split.
// Depends on sactag_pkg and the channel interfaces.
module sactag_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    sactag_req_if.sink          i_req,
    sactag_cfg_if.sink          i_cfg,
    input  logic                i_full,
    output logic                o_push,
    output sactag_pkg::t_work   o_work
);
    import sactag_pkg::*;

    logic [SBITS_W-1:0]    r_sbits;
    logic [OBITS_W-1:0]    r_obits;
    logic [WAYS_CFG_W-1:0] r_ways;

    logic [SBITS_W-1:0]    s_eff;
    logic [WAYS_CFG_W-1:0] ways_eff;
    logic [SHAMT_W-1:0]    tag_sh;
    logic [ADDR_W-1:0]     above_off;
    logic [SET_W-1:0]      set_mask;

    // Take configuration writes at any time; unknown indexes are dropped
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sbits <= SBITS_RST;
            r_obits <= OBITS_RST;
            r_ways  <= WAYS_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_SET_BITS:    r_sbits <= i_cfg.data[SBITS_W-1:0];
                CFG_OFFSET_BITS: r_obits <= i_cfg.data[OBITS_W-1:0];
                CFG_WAYS:        r_ways  <= i_cfg.data[WAYS_CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // Saturate set bits and way count to what the store holds; a way count of zero counts as one
    always_comb begin
        s_eff = (r_sbits > SBITS_W'(MAX_SET_BITS)) ? SBITS_W'(MAX_SET_BITS) : r_sbits;
        if (r_ways == '0) begin
            ways_eff = WAYS_CFG_W'(1);
        end else if (r_ways > WAYS_CFG_W'(NUM_WAYS)) begin
            ways_eff = WAYS_CFG_W'(NUM_WAYS);
        end else begin
            ways_eff = r_ways;
        end
    end

    // Split the address into set and tag
    always_comb begin
        tag_sh    = SHAMT_W'(s_eff) + SHAMT_W'(r_obits);
        above_off = i_req.address >> r_obits;
        set_mask  = ~({SET_W{1'b1}} << s_eff);
        o_work.func = i_req.func;
        o_work.set  = above_off[SET_W-1:0] & set_mask;
        o_work.tag  = TAG_W'(i_req.address >> tag_sh);
        o_work.ways = ways_eff;
    end

    // Accept whenever the queue has room
    assign i_req.ready = !i_full;
    assign o_push      = i_req.valid && !i_full;

endmodule

FILE: rtl/sactag_fifo.sv
// Short queue of classified items between front and back.
// Depends on sactag_pkg.
module sactag_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  sactag_pkg::t_work   i_work,
    output logic                o_full,
    input  logic                i_pop,
    output logic                o_valid,
    output sactag_pkg::t_work   o_work
);
    import sactag_pkg::*;

    t_work             r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QCNT_W-1:0] r_count;

    assign o_full  = (r_count == QCNT_W'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_work  = r_mem[r_rptr];

    // Store pushed items
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_work;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

FILE: rtl/sactag_back.sv
// Back end: read-modify-write of one set row, LRU choice, result register.
// Depends on sactag_pkg, sactag_rsp_if and sactag_ram.
module sactag_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_work_valid,
    input  sactag_pkg::t_work   i_work,
    output logic                o_pop,
    sactag_rsp_if.source        o_rsp
);
    import sactag_pkg::*;

    t_bstate           r_state;
    t_bstate           n_state;
    t_work             r_work;
    logic [STAMP_W-1:0] r_clock;
    logic              r_hit;
    logic              r_wb;
    logic [WAY_W-1:0]  r_way;
    logic [MAX_SETS-1:0] r_row_valid;
    t_rsp              r_out;
    logic              r_out_valid;

    logic              advance;
    logic [ROW_W-1:0]  ram_rdata;
    t_row              row_cur;
    t_row              row_new;

    logic [NUM_WAYS-1:0] in_use;
    logic [NUM_WAYS-1:0] hitv;
    logic [NUM_WAYS-1:0] invv;
    logic              any_hit;
    logic              any_inv;
    logic [WAY_W-1:0]  hit_way;
    logic [WAY_W-1:0]  inv_way;
    logic [WAY_W-1:0]  lru_way;
    logic [NUM_WAYS-1:0]              nd_cand;
    logic [NUM_WAYS-1:0][STAMP_W-1:0] nd_stamp;
    logic [NUM_WAYS-1:0][WAY_W-1:0]   nd_way;

    // Tag memory, one row per set
    sactag_ram #(
        .WIDTH (ROW_W),
        .DEPTH (MAX_SETS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (advance),
        .i_waddr (r_work.set),
        .i_wdata (row_new),
        .i_re    (o_pop),
        .i_raddr (i_work.set),
        .o_rdata (ram_rdata)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BS_IDLE:   if (i_work_valid) n_state = BS_LOOK;
            BS_LOOK:   n_state = BS_UPDATE;
            BS_UPDATE: if (!r_out_valid || o_rsp.ready) n_state = BS_IDLE;
            default:   n_state = BS_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        o_pop   = 1'b0;
        advance = 1'b0;
        unique case (r_state)
            BS_IDLE:   o_pop   = i_work_valid;
            BS_LOOK:   ;
            BS_UPDATE: advance = !r_out_valid || o_rsp.ready;
            default:   ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // A row never written reads as all zero
    assign row_cur = r_row_valid[r_work.set] ? t_row'(ram_rdata) : '0;

    // Search the ways in use for a hit and for a free way
    always_comb begin
        for (int w = 0; w < NUM_WAYS; w++) begin
            in_use[w] = WAYS_CFG_W'(w) < r_work.ways;
            hitv[w]   = in_use[w] && row_cur.valid[w] && (row_cur.tag[w] == r_work.tag);
            invv[w]   = in_use[w] && !row_cur.valid[w];
        end
        any_hit = |hitv;
        any_inv = |invv;
        hit_way = '0;
        inv_way = '0;
        for (int w = NUM_WAYS - 1; w >= 0; w--) begin
            if (hitv[w]) hit_way = WAY_W'(w);
            if (invv[w]) inv_way = WAY_W'(w);
        end
    end

    // Oldest stamp by a tree of compares; the lower way wins a tie
    always_comb begin
        for (int w = 0; w < NUM_WAYS; w++) begin
            nd_cand[w]  = in_use[w];
            nd_stamp[w] = row_cur.stamp[w];
            nd_way[w]   = WAY_W'(w);
        end
        for (int l = 0; l < LRU_LVLS; l++) begin
            for (int n = 0; n < (NUM_WAYS >> (l + 1)); n++) begin
                if (nd_cand[2*n] &&
                    (!nd_cand[2*n+1] || !(nd_stamp[2*n+1] < nd_stamp[2*n]))) begin
                    nd_cand[n]  = 1'b1;
                    nd_stamp[n] = nd_stamp[2*n];
                    nd_way[n]   = nd_way[2*n];
                end else begin
                    nd_cand[n]  = nd_cand[2*n+1];
                    nd_stamp[n] = nd_stamp[2*n+1];
                    nd_way[n]   = nd_way[2*n+1];
                end
            end
        end
        lru_way = nd_way[0];
    end

    // Latch the item, then the decision; advance the access clock
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_work <= i_work;
        end
        if (r_state == BS_LOOK) begin
            r_hit <= any_hit;
            r_wb  <= !any_hit && !any_inv && row_cur.dirty[lru_way];
            priority if (any_hit) begin
                r_way <= hit_way;
            end else if (any_inv) begin
                r_way <= inv_way;
            end else begin
                r_way <= lru_way;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock <= '0;
        end else if (r_state == BS_LOOK) begin
            r_clock <= r_clock + 1'b1;
        end
    end

    // Modify the row: stamp the way used, fill it on a miss
    always_comb begin
        row_new = row_cur;
        row_new.stamp[r_way] = r_clock;
        if (r_hit) begin
            row_new.dirty[r_way] = row_cur.dirty[r_way] | r_work.func;
        end else begin
            row_new.valid[r_way] = 1'b1;
            row_new.tag[r_way]   = r_work.tag;
            row_new.dirty[r_way] = r_work.func;
        end
    end

    // Mark rows once written
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_valid <= '0;
        end else if (advance) begin
            r_row_valid[r_work.set] <= 1'b1;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out.hit       <= r_hit;
            r_out.writeback <= r_wb;
            r_out.way_used  <= r_way;
            r_out.was_write <= r_work.func;
        end
    end

    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.hit       = r_out.hit;
    assign o_rsp.writeback = r_out.writeback;
    assign o_rsp.way_used  = r_out.way_used;
    assign o_rsp.was_write = r_out.was_write;

endmodule

FILE: rtl/sactag_chk.sv
// Port-level checker for the cache tag store, bound to the top level.
// Depends on sactag_pkg for the queue depth.
module sactag_chk (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_req_valid,
    input logic i_req_ready,
    input logic i_rsp_valid,
    input logic i_rsp_ready,
    input logic i_rsp_hit,
    input logic i_rsp_writeback
);
    import sactag_pkg::*;

    logic [2:0] r_outst;

    // Count items taken but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outst <= '0;
        end else begin
            r_outst <= r_outst + 3'(i_req_valid && i_req_ready)
                               - 3'(i_rsp_valid && i_rsp_ready);
        end
    end

    a_no_orphan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> r_outst != '0)
        else $error("result without an outstanding request");

    a_capacity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_outst <= 3'(QDEPTH + 2))
        else $error("more items in flight than the block can hold");

    a_hit_no_wb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_hit |-> !i_rsp_writeback)
        else $error("write-back reported on a hit");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid)
        else $error("result dropped while stalled");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("result valid straight after reset");

endmodule

bind set_assoc_lru_writeback_cache_tags_top sactag_chk u_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_req_valid     (i_req.valid),
    .i_req_ready     (i_req.ready),
    .i_rsp_valid     (o_rsp.valid),
    .i_rsp_ready     (o_rsp.ready),
    .i_rsp_hit       (o_rsp.hit),
    .i_rsp_writeback (o_rsp.writeback)
);
